// ===== design/mbpf_pkg.sv =====
// mbpf_pkg: shared widths, command codes, register indexes and structs
// for the masked byte pattern finder. No dependencies.

package mbpf_pkg;

    // Defaults for the top-level parameters
    localparam int PATTERN_MAX_DEF = 64;
    localparam int OFFSET_BITS_DEF = 32;

    // Field widths
    localparam int BYTE_W     = 8;
    localparam int CMD_W      = 2;
    localparam int IN_IDX_W   = 6;
    localparam int CFG_LEN_W  = 7;
    localparam int CFG_OFS_W  = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int OUT_OFS_W  = 32;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 32;

    // Input word commands
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_SCAN    = 2'd1,
        CMD_RESTART = 2'd2
    } cmd_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET   = 1'b1;

    // Decoded operation handed to the matcher (scan and restart already qualified by the stage fire)
    typedef struct packed {
        logic scan;
        logic restart;
        logic last;
    } mbpf_op_t;

    // Result of one scanned byte
    typedef struct packed {
        logic                 valid;
        logic                 found;
        logic [OUT_OFS_W-1:0] offset;
    } mbpf_res_t;

endpackage

// ===== design/mbpf_pattern_store.sv =====
// mbpf_pattern_store: pattern bytes and must-match bits, one entry per
// pattern position, each read in parallel. Depends on mbpf_pkg.

module mbpf_pattern_store
    import mbpf_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               load_en,
    input  logic [IN_IDX_W-1:0]                load_idx,
    input  logic [BYTE_W-1:0]                  load_byte,
    input  logic                               load_must,
    output logic [PATTERN_MAX-1:0][BYTE_W-1:0] pat,
    output logic [PATTERN_MAX-1:0]             mask
);

    logic [PATTERN_MAX-1:0][BYTE_W-1:0] pat_reg;
    logic [PATTERN_MAX-1:0]             mask_reg;

    // pattern bytes: no reset, only read where the mask bit is set
    always_ff @(posedge aclk) begin
        for (int j = 0; j < PATTERN_MAX; j++) begin
            if (load_en && (int'(load_idx) == j)) begin
                pat_reg[j] <= load_byte;
            end
        end
    end

    // must-match bits; entries past the index range are never addressed and stay wildcards
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else begin
            for (int j = 0; j < PATTERN_MAX; j++) begin
                if (load_en && (int'(load_idx) == j)) begin
                    mask_reg[j] <= load_must;
                end
            end
        end
    end

    assign pat  = pat_reg;
    assign mask = mask_reg;

endmodule

// ===== design/mbpf_matcher.sv =====
// mbpf_matcher: byte window, byte counter, scan-done flag and the parallel
// masked compare of the window ending at the newest byte. Depends on mbpf_pkg.

module mbpf_matcher
    import mbpf_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  mbpf_op_t                           op,
    input  logic [BYTE_W-1:0]                  data_byte,
    input  logic [LEN_W-1:0]                   act_len,
    input  logic [CFG_OFS_W-1:0]               start_offset,
    input  logic [PATTERN_MAX-1:0][BYTE_W-1:0] pat,
    input  logic [PATTERN_MAX-1:0]             mask,
    output mbpf_res_t                          res
);

    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int CMP_W = (OFFSET_BITS > CFG_OFS_W) ? OFFSET_BITS : CFG_OFS_W;

    logic [PATTERN_MAX-1:0][BYTE_W-1:0] win_reg;
    logic [PATTERN_MAX-1:0][BYTE_W-1:0] win_next;
    logic [OFFSET_BITS-1:0]             cnt_reg;
    logic [OFFSET_BITS-1:0]             cnt_next;
    logic                               done_reg;
    logic [PATTERN_MAX-1:0]             pos_ok;
    logic [CMP_W-1:0]                   cnt_ext;
    logic [CMP_W-1:0]                   len_ext;
    logic [CMP_W-1:0]                   win_start;
    logic                               eligible;
    logic                               hit;
    logic                               take;

    assign take = op.scan && !done_reg;

    // Window after the new byte: index 0 is the newest byte
    always_comb begin
        win_next[0] = data_byte;
        for (int k = 1; k < PATTERN_MAX; k++) begin
            win_next[k] = win_reg[k-1];
        end
    end

    // Saturating byte count
    assign cnt_next = (&cnt_reg) ? cnt_reg : cnt_reg + 1'b1;

    // Pattern position j lines up with the byte act_len-1-j places back
    for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cmp
        logic             in_use;
        logic [LEN_W-1:0] sel;
        assign in_use   = LEN_W'(j) < act_len;
        assign sel      = act_len - LEN_W'(j) - LEN_W'(1);
        assign pos_ok[j] = !in_use || !mask[j] || (pat[j] == win_next[sel[IDX_W-1:0]]);
    end

    // Window start must exist and lie at or after the start offset
    assign cnt_ext   = CMP_W'(cnt_next);
    assign len_ext   = CMP_W'(act_len);
    assign win_start = cnt_ext - len_ext;
    assign eligible  = (cnt_ext >= len_ext) && (win_start >= CMP_W'(start_offset));
    assign hit       = eligible && (&pos_ok);

    always_comb begin
        res.valid  = take && (hit || op.last);
        res.found  = hit;
        res.offset = hit ? win_start[OUT_OFS_W-1:0] : '0;
    end

    // Window bytes: only bytes of the current run are ever compared
    always_ff @(posedge aclk) begin
        if (take) begin
            win_reg <= win_next;
        end
    end

    // Scan control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (op.restart) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (take) begin
            cnt_reg  <= cnt_next;
            done_reg <= hit || op.last;
        end
    end

`ifndef SYNTHESIS
    // a result always ends the scan
    assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |=> done_reg)
        else $error("scan not marked done after a result");

    // nothing is reported once the scan has ended
    assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !res.valid)
        else $error("result after scan end");

    // restart clears the scan state
    assert property (@(posedge aclk) disable iff (!aresetn)
        op.restart |=> (cnt_reg == '0) && !done_reg)
        else $error("restart did not clear scan state");
`endif

endmodule

// ===== design/masked_byte_pattern_finder_core.sv =====
// masked_byte_pattern_finder_core: top level with input word register,
// config registers and result register. Depends on mbpf_pkg,
// mbpf_pattern_store and mbpf_matcher.
//
//   channel  dir  handshake          payload
//   s_       in   s_tvalid/s_tready  s_tdata, s_tuser (command), s_tlast (last byte)
//   m_       out  m_tvalid/m_tready  m_tdata (match offset), m_tuser (found)
//   cfg_     in   cfg_we             cfg_index, cfg_wdata
//
// One word per cycle sustained while a full result register is being taken; a scanned
// byte's result word reaches m_ through the input register, then the result register.
// The compare of all pattern positions is one pass between those registers.
// Reset (aresetn, synchronous, active low) clears control state and mask bits.
// A full result register that is not taken holds the input stage; the input
// register still takes a word while it is empty.

module masked_byte_pattern_finder_core
    import mbpf_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input words
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [5:0] pattern_index, [13:6] pattern_byte, [14] must_match, [22:15] data_byte
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [1:0] command
    input  logic [CMD_W-1:0]      s_tuser,
    input  logic                  s_tlast,
    // result words
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [31:0] match_offset
    output logic [M_TDATA_W-1:0]  m_tdata,
    // [0] found
    output logic                  m_tuser,
    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    logic                  in_valid_reg;
    logic [CMD_W-1:0]      in_cmd_reg;
    logic [IN_IDX_W-1:0]   in_idx_reg;
    logic [BYTE_W-1:0]     in_pbyte_reg;
    logic                  in_must_reg;
    logic [BYTE_W-1:0]     in_dbyte_reg;
    logic                  in_last_reg;

    logic [LEN_W-1:0]      len_reg;
    logic [LEN_W-1:0]      len_next;
    logic [CFG_OFS_W-1:0]  start_reg;

    logic                  m_valid_reg;
    logic                  m_found_reg;
    logic [OUT_OFS_W-1:0]  m_offset_reg;

    logic                  advance;
    logic                  fire;
    logic                  load_en;
    mbpf_op_t              op;
    mbpf_res_t             res;

    logic [PATTERN_MAX-1:0][BYTE_W-1:0] pat;
    logic [PATTERN_MAX-1:0]             mask;

    // Stage handshake
    assign advance  = !m_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // Input word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg   <= s_tuser;
            in_idx_reg   <= s_tdata[5:0];
            in_pbyte_reg <= s_tdata[13:6];
            in_must_reg  <= s_tdata[14];
            in_dbyte_reg <= s_tdata[22:15];
            in_last_reg  <= s_tlast;
        end
    end

    // Command decode
    always_comb begin
        load_en    = 1'b0;
        op.scan    = 1'b0;
        op.restart = 1'b0;
        op.last    = in_last_reg;
        case (cmd_t'(in_cmd_reg))
            CMD_LOAD:    load_en    = fire;
            CMD_SCAN:    op.scan    = fire;
            CMD_RESTART: op.restart = fire;
            default:     ;
        endcase
    end

    // Pattern length clamped into 1..PATTERN_MAX when written
    always_comb begin
        if (cfg_wdata[CFG_LEN_W-1:0] == '0) begin
            len_next = LEN_W'(1);
        end else if (int'(cfg_wdata[CFG_LEN_W-1:0]) > PATTERN_MAX) begin
            len_next = LEN_W'(PATTERN_MAX);
        end else begin
            len_next = LEN_W'(cfg_wdata[CFG_LEN_W-1:0]);
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= LEN_W'(1);
            start_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PATTERN_LENGTH: len_reg   <= len_next;
                REG_START_OFFSET:   start_reg <= cfg_wdata[CFG_OFS_W-1:0];
                default:            ;
            endcase
        end
    end

    mbpf_pattern_store #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load_en   (load_en),
        .load_idx  (in_idx_reg),
        .load_byte (in_pbyte_reg),
        .load_must (in_must_reg),
        .pat       (pat),
        .mask      (mask)
    );

    mbpf_matcher #(
        .PATTERN_MAX (PATTERN_MAX),
        .OFFSET_BITS (OFFSET_BITS),
        .LEN_W       (LEN_W)
    ) u_matcher (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .op           (op),
        .data_byte    (in_dbyte_reg),
        .act_len      (len_reg),
        .start_offset (start_reg),
        .pat          (pat),
        .mask         (mask),
        .res          (res)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= fire && res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && res.valid) begin
            m_found_reg  <= res.found;
            m_offset_reg <= res.offset;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = m_offset_reg;

`ifndef SYNTHESIS
    // not-found words carry a zero offset
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("not-found word with nonzero offset");

    // an empty input register never blocks the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stalled while input register empty");

    // a produced result shows up on the output next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && res.valid) |=> m_tvalid)
        else $error("result lost at result register");
`endif

endmodule

// ===== sim/masked_byte_pattern_finder_core_test.sv =====
`timescale 1ns / 1ps
// masked_byte_pattern_finder_core_test: self-checking bench for the masked byte
// pattern finder. It predicts every scan report and checks it on the m_ stream.
// Depends on mbpf_pkg and masked_byte_pattern_finder_core.

module masked_byte_pattern_finder_core_test;
    import mbpf_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int RANDOM_WORDS   = 500;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [IN_IDX_W-1:0] pattern_index;
        logic [BYTE_W-1:0]   pattern_byte;
        logic                must_match;
        logic [BYTE_W-1:0]   data_byte;
        logic                last_byte;
    } scan_word_t;

    typedef struct packed {
        logic                 found;
        logic [OUT_OFS_W-1:0] offset;
    } scan_report_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [CMD_W-1:0]      s_tuser   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    masked_byte_pattern_finder_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Predicted block state and register copies
    logic [BYTE_W-1:0]    pat_bytes [PATTERN_MAX_DEF] = '{default: 8'h00};
    logic                 pat_must  [PATTERN_MAX_DEF] = '{default: 1'b0};
    logic [BYTE_W-1:0]    win_bytes [PATTERN_MAX_DEF] = '{default: 8'h00};
    logic [OUT_OFS_W-1:0] bytes_seen = '0;
    logic                 scan_over  = 1'b0;
    logic [CFG_LEN_W-1:0] cfg_len    = 7'd1;
    logic [CFG_OFS_W-1:0] cfg_start  = '0;

    scan_word_t   words_to_send [$];
    scan_report_t reports_due [$];
    scan_word_t   cur_word;
    int  words_in_flight = 0;
    int  send_gap = 0;
    int  recv_stall = 0;
    int  quiet_cycles = 0;
    bit  calm = 1'b0;
    bit  counting = 1'b0;
    int  rand_words = 0;
    int  n_accepted = 0;
    int  n_reports = 0;
    int  n_found = 0;
    int  n_errors = 0;
    int  n_phases = 0;

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 13);
    endfunction

    // Window that ends at the newest byte: pattern[j] faces the j-th byte of it
    function automatic bit window_hit(input int unsigned len);
        for (int j = 0; j < len; j++)
            if (pat_must[j] && pat_bytes[j] != win_bytes[len - 1 - j])
                return 1'b0;
        return 1'b1;
    endfunction

    // Advance the predicted state by one accepted word, queue any report
    function automatic void search_step(input scan_word_t w);
        int unsigned          len;
        logic [OUT_OFS_W-1:0] first;
        scan_report_t         rep;
        case (w.command)
            CMD_LOAD: begin
                pat_bytes[w.pattern_index] = w.pattern_byte;
                pat_must[w.pattern_index]  = w.must_match;
            end
            CMD_RESTART: begin
                foreach (win_bytes[k])
                    win_bytes[k] = 8'h00;
                bytes_seen = '0;
                scan_over  = 1'b0;
            end
            CMD_SCAN: if (!scan_over) begin
                for (int k = PATTERN_MAX_DEF - 1; k > 0; k--)
                    win_bytes[k] = win_bytes[k - 1];
                win_bytes[0] = w.data_byte;
                // count saturates instead of wrapping
                if (bytes_seen != '1)
                    bytes_seen++;
                len = (cfg_len == 0) ? 1 :
                      (cfg_len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : cfg_len;
                if (bytes_seen >= len) begin
                    first = bytes_seen - len;
                    if (first >= cfg_start && window_hit(len)) begin
                        scan_over  = 1'b1;
                        rep.found  = 1'b1;
                        rep.offset = first;
                        reports_due.push_back(rep);
                    end
                end
                // last byte without a hit ends the section as not found
                if (!scan_over && w.last_byte) begin
                    scan_over  = 1'b1;
                    rep.found  = 1'b0;
                    rep.offset = '0;
                    reports_due.push_back(rep);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic scan_word_t random_word();
        logic [31:0] r;
        r = $urandom;
        return r[$bits(scan_word_t)-1:0];
    endfunction

    function automatic void send_word(input scan_word_t w);
        words_to_send.push_back(w);
        words_in_flight++;
        if (counting && w.command != CMD_UNUSED)
            rand_words++;
    endfunction

    // Unused fields of each word stay random
    function automatic void send_load(input logic [IN_IDX_W-1:0] idx,
                                      input logic [BYTE_W-1:0] b, input logic m);
        scan_word_t w;
        w = random_word();
        w.command       = CMD_LOAD;
        w.pattern_index = idx;
        w.pattern_byte  = b;
        w.must_match    = m;
        send_word(w);
    endfunction

    function automatic void send_scan(input logic [BYTE_W-1:0] d, input logic last);
        scan_word_t w;
        w = random_word();
        w.command   = CMD_SCAN;
        w.data_byte = d;
        w.last_byte = last;
        send_word(w);
    endfunction

    function automatic void send_cmd(input logic [CMD_W-1:0] c);
        scan_word_t w;
        w = random_word();
        w.command = c;
        send_word(w);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == REG_PATTERN_LENGTH)
            cfg_len = value[CFG_LEN_W-1:0];
        else
            cfg_start = value;
    endtask

    // Idle: every word taken, every report seen, pipeline drained
    task automatic wait_idle();
        while (words_in_flight != 0 || reports_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Input word driver with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                search_step(cur_word);
                words_in_flight--;
                n_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap != 0) begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (words_to_send.size() != 0) begin
                    cur_word = words_to_send.pop_front();
                    s_tdata  <= {1'b0, cur_word.data_byte, cur_word.must_match,
                                 cur_word.pattern_byte, cur_word.pattern_index};
                    s_tuser  <= cur_word.command;
                    s_tlast  <= cur_word.last_byte;
                    s_tvalid <= 1'b1;
                    send_gap <= draw_wait();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Report monitor with random stalls
    always @(posedge aclk) begin : result_check
        scan_report_t due;
        int           stall;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            recv_stall <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_reports++;
                if (reports_due.size() == 0) begin
                    $error("unexpected report: found=%0d match_offset=%0d", m_tuser, m_tdata);
                    n_errors++;
                end else begin
                    due = reports_due.pop_front();
                    if (m_tuser !== due.found) begin
                        $error("found: expected %0d, got %0d", due.found, m_tuser);
                        n_errors++;
                    end
                    if (m_tdata !== due.offset) begin
                        $error("match_offset: expected %0d, got %0d", due.offset, m_tdata);
                        n_errors++;
                    end
                    if (due.found)
                        n_found++;
                end
                stall = draw_wait();
            end else if (recv_stall != 0) begin
                stall = recv_stall - 1;
            end else begin
                stall = 0;
            end
            recv_stall <= stall;
            m_tready   <= (stall == 0);
        end
    end

    // Watchdog: too long without a word moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus and phase control
    initial begin
        int          pick;
        int          len_val;
        int          act_len;
        int          nsect;
        int          sect_len;
        int          at;
        int          extra;
        logic [31:0] wdata;
        logic [31:0] start_val;
        logic [7:0]  plan [PATTERN_MAX_DEF];
        logic [7:0]  sect [128];
        bit          wild;
        bit          narrow;
        bit          broken;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // write every pattern entry once, all wildcards
        for (int j = 0; j < PATTERN_MAX_DEF; j++)
            send_load(IN_IDX_W'(j), BYTE_W'($urandom_range(0, 255)), 1'b0);

        // defaults after reset: length 1, all wildcards -> hit at offset 0
        send_scan(8'h00, 1'b0);
        send_scan(8'hFF, 1'b0);     // scan already ended, ignored
        send_cmd(CMD_UNUSED);
        send_cmd(CMD_RESTART);
        send_load(6'd0, 8'hFF, 1'b1);
        send_load(6'd63, 8'h00, 1'b1);
        send_scan(8'h00, 1'b0);
        send_scan(8'hFF, 1'b1);     // hit on the last byte wins over not-found
        send_cmd(CMD_RESTART);
        send_scan(8'h12, 1'b1);     // miss, not found
        wait_idle();

        // start offset past the end of the section
        write_reg(REG_START_OFFSET, 32'hFFFF_FFFF);
        send_cmd(CMD_RESTART);
        send_scan(8'hFF, 1'b0);
        send_scan(8'hFF, 1'b1);
        wait_idle();

        // length 0 clamps to 1; upper data bits are not part of the register
        write_reg(REG_START_OFFSET, 32'h0);
        write_reg(REG_PATTERN_LENGTH, 32'hFFFF_FF80);
        send_cmd(CMD_RESTART);
        send_scan(8'hFF, 1'b0);
        wait_idle();

        // length 127 clamps to 64; stream too short for any window
        write_reg(REG_PATTERN_LENGTH, 32'h0000_007F);
        send_cmd(CMD_RESTART);
        send_scan(8'h00, 1'b0);
        send_scan(8'hFF, 1'b1);
        wait_idle();

        // Random phases: new settings, new pattern, one to four sections each
        counting = 1'b1;
        while (rand_words < RANDOM_WORDS) begin
            n_phases++;
            calm = ($urandom_range(0, 3) == 0);

            pick = $urandom_range(0, 9);
            if (pick == 0)
                len_val = PATTERN_MAX_DEF;
            else if (pick == 1)
                len_val = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
            else
                len_val = $urandom_range(1, 8);
            act_len = (len_val == 0) ? 1 : (len_val > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : len_val;
            wdata = $urandom;
            wdata[CFG_LEN_W-1:0] = CFG_LEN_W'(len_val);
            write_reg(REG_PATTERN_LENGTH, wdata);

            pick = $urandom_range(0, 7);
            if (pick == 0)
                start_val = $urandom;
            else if (pick < 3)
                start_val = $urandom_range(1, 24);
            else
                start_val = 0;
            write_reg(REG_START_OFFSET, start_val);

            wild = ($urandom_range(0, 7) == 0);
            for (int j = 0; j < act_len; j++) begin
                plan[j] = BYTE_W'($urandom_range(0, 255));
                send_load(IN_IDX_W'(j), plan[j], !wild && $urandom_range(0, 3) != 0);
            end

            nsect = $urandom_range(1, 4);
            for (int s = 0; s < nsect; s++) begin
                send_cmd(CMD_RESTART);
                if (act_len == PATTERN_MAX_DEF)
                    sect_len = $urandom_range(40, 90);
                else
                    sect_len = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 16);
                // narrow alphabet makes accidental partial hits likely
                narrow = $urandom_range(0, 1);
                for (int k = 0; k < sect_len; k++)
                    sect[k] = narrow ? plan[$urandom_range(0, act_len - 1)]
                                     : BYTE_W'($urandom_range(0, 255));
                if (sect_len >= act_len && $urandom_range(0, 1)) begin
                    at = $urandom_range(0, sect_len - act_len);
                    for (int k = 0; k < act_len; k++)
                        sect[at + k] = plan[k];
                end
                // some sections lose their last marker and are cut by a restart
                broken = ($urandom_range(0, 5) == 0);
                for (int k = 0; k < sect_len; k++) begin
                    if ($urandom_range(0, 19) == 0) begin
                        if ($urandom_range(0, 1))
                            send_cmd(CMD_UNUSED);
                        else
                            send_load(IN_IDX_W'($urandom_range(0, 63)),
                                      BYTE_W'($urandom_range(0, 255)),
                                      1'($urandom_range(0, 1)));
                    end
                    send_scan(sect[k], (k == sect_len - 1) && !broken);
                end
                extra = $urandom_range(0, 2);
                for (int k = 0; k < extra; k++)
                    send_scan(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            wait_idle();
        end

        wait_idle();
        $display("Run: %0d words accepted (%0d random) over %0d random setting phases.",
                 n_accepted, rand_words, n_phases);
        $display("Reports: %0d checked, %0d with a match, %0d not found, %0d mismatches.",
                 n_reports, n_found, n_reports - n_found, n_errors);
        if (n_errors == 0 && reports_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
design/mbpf_pkg.sv
design/mbpf_pattern_store.sv
design/mbpf_matcher.sv
design/masked_byte_pattern_finder_core.sv
sim/masked_byte_pattern_finder_core_test.sv
